### rtl/tts_pkg.sv
package tts_pkg;

  localparam int unsigned MaxWidth   = 512;
  localparam int unsigned MaxHeight  = 1024;
  localparam int unsigned HalfSize   = MaxWidth * 4;
  localparam int unsigned StoreDepth = 2 * HalfSize;

  localparam int unsigned AddrW    = $clog2(StoreDepth);
  localparam int unsigned OffW     = $clog2(HalfSize);
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned RowW     = $clog2(MaxHeight);
  localparam int unsigned WidthW   = 10;
  localparam int unsigned HeightW  = 11;
  localparam int unsigned PixW     = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  localparam logic [WidthW-1:0]  WidthReset  = WidthW'(512);
  localparam logic [HeightW-1:0] HeightReset = HeightW'(4);

  typedef enum logic {
    OpPixel = 1'b0,
    OpDrain = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth  = CfgIdxW'(0),
    RegImageHeight = CfgIdxW'(1)
  } cfg_reg_e;

  typedef struct packed {
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [PixW-1:0]  wr_data;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic en;
    logic image_end;
  } rd_tag_t;

endpackage

### rtl/tts_if.sv
interface tts_in_if;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [tts_pkg::PixW-1:0] pixel_in;

  modport source (output valid, output opcode, output pixel_in, input ready);
  modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

interface tts_out_if;
  logic                     valid;
  logic                     ready;
  logic [tts_pkg::PixW-1:0] pixel_out;
  logic                     image_end;

  modport source (output valid, output pixel_out, output image_end, input ready);
  modport sink   (input valid, input pixel_out, input image_end, output ready);
endinterface

interface tts_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tts_pkg::CfgIdxW-1:0]  index;
  logic [tts_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/tts_band_ram.sv
module tts_band_ram (
  input  logic                      clk_i,
  input  tts_pkg::mem_req_t         req_i,
  output logic [tts_pkg::PixW-1:0]  rd_data_o
);

  logic [tts_pkg::PixW-1:0] mem [tts_pkg::StoreDepth];
  logic [tts_pkg::PixW-1:0] rd_data_q;

  // read-first: a same-edge write never disturbs the read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/tts_ctrl.sv
module tts_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tts_in_if.sink               in_i,
  tts_cfg_if.sink              cfg_i,
  input  logic                 free_i,
  output tts_pkg::mem_req_t    mem_req_o,
  output tts_pkg::rd_tag_t     rd_tag_o
);

  logic [tts_pkg::WidthW-1:0]  width_q, width_d;
  logic [tts_pkg::HeightW-1:0] height_q, height_d;
  logic [tts_pkg::ColW-1:0]    col_q, col_d;
  logic [tts_pkg::RowW-1:0]    row_q, row_d;
  logic                        wr_half_q, wr_half_d;
  logic [tts_pkg::OffW-1:0]    rd_idx_q, rd_idx_d;
  logic                        rd_half_q, rd_half_d;
  logic [1:0]                  ready_q, ready_d;
  logic [1:0]                  final_q, final_d;

  logic [tts_pkg::WidthW-1:0]  w_used;
  logic [tts_pkg::HeightW-1:0] h_used;
  logic                        step;
  logic                        rd_en;
  logic                        rd_last;
  logic                        wr_en;
  logic                        row_end;
  logic                        last_row;
  logic                        band_done;
  logic [1:0]                  ready_mid;
  logic [1:0]                  final_mid;
  logic [tts_pkg::OffW-1:0]    wr_off;

  always_comb begin
    w_used = width_q;
    if (width_q < tts_pkg::WidthW'(8)) begin
      w_used = tts_pkg::WidthW'(8);
    end else if (width_q > tts_pkg::WidthW'(tts_pkg::MaxWidth)) begin
      w_used = tts_pkg::WidthW'(tts_pkg::MaxWidth);
    end
    w_used[2:0] = 3'b000;
    h_used = height_q;
    if (height_q < tts_pkg::HeightW'(4)) begin
      h_used = tts_pkg::HeightW'(4);
    end else if (height_q > tts_pkg::HeightW'(tts_pkg::MaxHeight)) begin
      h_used = tts_pkg::HeightW'(tts_pkg::MaxHeight);
    end
    h_used[1:0] = 2'b00;
  end

  assign in_i.ready  = free_i;
  assign cfg_i.ready = 1'b1;
  assign step        = in_i.valid && free_i;

  assign rd_en   = step && ready_q[rd_half_q];
  assign rd_last = ({1'b0, rd_idx_q} + (tts_pkg::OffW + 1)'(1)) >= {w_used, 2'b00};

  always_comb begin
    ready_mid = ready_q;
    final_mid = final_q;
    if (rd_en && rd_last) begin
      ready_mid[rd_half_q] = 1'b0;
      final_mid[rd_half_q] = 1'b0;
    end
  end

  assign wr_en     = step && (in_i.opcode == tts_pkg::OpPixel) && !ready_mid[wr_half_q];
  assign row_end   = ({1'b0, col_q} + tts_pkg::WidthW'(1)) >= w_used;
  assign last_row  = ({1'b0, row_q} + tts_pkg::HeightW'(1)) >= h_used;
  assign band_done = wr_en && row_end && ((row_q[1:0] == 2'b11) || last_row);
  assign wr_off    = {col_q[tts_pkg::ColW-1:3], row_q[1:0], col_q[2:0]};

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    col_d     = col_q;
    row_d     = row_q;
    wr_half_d = wr_half_q;
    rd_idx_d  = rd_idx_q;
    rd_half_d = rd_half_q;
    ready_d   = ready_mid;
    final_d   = final_mid;

    if (cfg_i.valid) begin
      case (cfg_i.index)
        tts_pkg::RegImageWidth:  width_d  = cfg_i.data[tts_pkg::WidthW-1:0];
        tts_pkg::RegImageHeight: height_d = cfg_i.data;
        default: ;
      endcase
    end

    if (rd_en) begin
      if (rd_last) begin
        rd_idx_d  = '0;
        rd_half_d = !rd_half_q;
      end else begin
        rd_idx_d = rd_idx_q + tts_pkg::OffW'(1);
      end
    end

    if (wr_en) begin
      if (!row_end) begin
        col_d = col_q + tts_pkg::ColW'(1);
      end else begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + tts_pkg::RowW'(1);
      end
      if (band_done) begin
        ready_d[wr_half_q] = 1'b1;
        final_d[wr_half_q] = last_row;
        wr_half_d          = !wr_half_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= tts_pkg::WidthReset;
      height_q  <= tts_pkg::HeightReset;
      col_q     <= '0;
      row_q     <= '0;
      wr_half_q <= 1'b0;
      rd_idx_q  <= '0;
      rd_half_q <= 1'b0;
      ready_q   <= 2'b00;
      final_q   <= 2'b00;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      col_q     <= col_d;
      row_q     <= row_d;
      wr_half_q <= wr_half_d;
      rd_idx_q  <= rd_idx_d;
      rd_half_q <= rd_half_d;
      ready_q   <= ready_d;
      final_q   <= final_d;
    end
  end

  assign mem_req_o.wr_en   = wr_en;
  assign mem_req_o.wr_addr = {wr_half_q, wr_off};
  assign mem_req_o.wr_data = in_i.pixel_in;
  assign mem_req_o.rd_en   = rd_en;
  assign mem_req_o.rd_addr = {rd_half_q, rd_idx_q};

  assign rd_tag_o.en        = rd_en;
  assign rd_tag_o.image_end = rd_last && final_q[rd_half_q];

  a_no_write_into_read_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en && !rd_last) |-> (wr_half_q != rd_half_q))
    else $error("write hit the half being read");

  a_band_on_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    band_done |=> ready_q[$past(wr_half_q)] && (col_q == '0))
    else $error("band finished without marking its half ready");

  a_readout_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && rd_last) |=> (rd_idx_q == '0) && (rd_half_q != $past(rd_half_q)))
    else $error("read-out did not restart on the other half");

endmodule

### rtl/tts_out_stage.sv
module tts_out_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tts_pkg::rd_tag_t          rd_tag_i,
  input  logic [tts_pkg::PixW-1:0]  rd_data_i,
  output logic                      free_o,
  tts_out_if.source                 out_o
);

  logic                     s1_valid_q, s1_valid_d;
  logic                     s1_end_q;
  logic                     out_valid_q, out_valid_d;
  logic [tts_pkg::PixW-1:0] pix_q;
  logic                     end_q;
  logic                     s1_move;

  assign s1_move = !out_valid_q || out_o.ready;
  assign free_o  = !s1_valid_q || s1_move;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (rd_tag_i.en) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = s1_move ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_tag_i.en) begin
      s1_end_q <= rd_tag_i.image_end;
    end
    if (s1_move && s1_valid_q) begin
      pix_q <= rd_data_i;
      end_q <= s1_end_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pixel_out = pix_q;
  assign out_o.image_end = end_q;

  a_read_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_tag_i.en |-> free_o)
    else $error("memory read issued into a full stage");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |=> s1_valid_q && $stable(s1_end_q))
    else $error("read stage lost its transaction");

  a_s1_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_move) |=> out_valid_q)
    else $error("read stage advanced without filling the output");

endmodule

### rtl/texture_tile_swizzle_8bit_top.sv
// channel  dir  payload                     accepted when
// in_i     in   opcode, pixel_in            in_i.valid && in_i.ready
// out_o    out  pixel_out, image_end        out_o.valid && out_o.ready
// cfg_i    in   index, data                 cfg_i.valid && cfg_i.ready (always ready)
//
// One transaction per cycle while in_i.ready is high; a result passes through two registers
// in order (band memory read, then output register).
// The band memory (4096 x 8, one write and one read port) sets the rate: each
// transaction does at most one read and one write of it.
// Reset clears counters and half flags; the band memory is not cleared.
// A stalled output holds one result in the output register and one in the read
// stage; in_i stalls only when both are full.
module texture_tile_swizzle_8bit_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  tts_in_if.sink    in_i,
  tts_cfg_if.sink   cfg_i,
  tts_out_if.source out_o
);

  tts_pkg::mem_req_t        mem_req;
  tts_pkg::rd_tag_t         rd_tag;
  logic [tts_pkg::PixW-1:0] rd_data;
  logic                     free;

  tts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg_i),
    .free_i    (free),
    .mem_req_o (mem_req),
    .rd_tag_o  (rd_tag)
  );

  tts_band_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  tts_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_tag_i  (rd_tag),
    .rd_data_i (rd_data),
    .free_o    (free),
    .out_o     (out_o)
  );

endmodule

### test/tb_texture_tile_swizzle_8bit_top.sv
module tb_texture_tile_swizzle_8bit_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned IdlePct    = 37;
  localparam int unsigned RandomStop = 900;
  localparam logic [tts_pkg::PixW-1:0] CornerPx [8] = '{8'h00, 8'hFF, 8'h55, 8'hAA,
                                                        8'h01, 8'h80, 8'h7F, 8'hFE};

  typedef struct packed {
    tts_pkg::op_e             op;
    logic [tts_pkg::PixW-1:0] pixel;
  } pix_txn_t;

  typedef struct packed {
    logic [tts_pkg::PixW-1:0] pixel;
    logic                     last;
  } tile_txn_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tts_in_if  pix_if ();
  tts_out_if tile_if ();
  tts_cfg_if reg_if ();

  texture_tile_swizzle_8bit_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pix_if),
    .cfg_i  (reg_if),
    .out_o  (tile_if)
  );

  always #10ns clk_i = ~clk_i;

  pix_txn_t    pending_q[$];
  tile_txn_t   tiled_q[$];
  int unsigned items_queued = 0;
  int unsigned items_sent   = 0;
  int unsigned fail_count   = 0;
  int unsigned stuck        = 0;
  bit          pix_taken    = 1'b0;
  bit          calm         = 1'b0;

  // swizzle predictor state
  logic [tts_pkg::PixW-1:0]    band_mem [tts_pkg::StoreDepth];
  int unsigned                 wr_col  = 0;
  int unsigned                 wr_row  = 0;
  int unsigned                 rd_idx  = 0;
  bit                          wr_half = 1'b0;
  bit                          rd_half = 1'b0;
  bit                          half_full [2] = '{1'b0, 1'b0};
  bit                          half_final [2] = '{1'b0, 1'b0};
  logic [tts_pkg::WidthW-1:0]  cfg_width  = tts_pkg::WidthReset;
  logic [tts_pkg::HeightW-1:0] cfg_height = tts_pkg::HeightReset;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = cfg_width;
    if (w < 8) w = 8;
    if (w > tts_pkg::MaxWidth) w = tts_pkg::MaxWidth;
    return w & ~32'd7;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = cfg_height;
    if (h < 4) h = 4;
    if (h > tts_pkg::MaxHeight) h = tts_pkg::MaxHeight;
    return h & ~32'd3;
  endfunction

  function automatic void swizzle_step(pix_txn_t t);
    int unsigned w, h, idx, col, row, off;
    bit          last, row_end, final_row;
    tile_txn_t   r;
    w = eff_width();
    h = eff_height();
    // read out the finished half first
    if (half_full[rd_half]) begin
      idx = rd_idx % tts_pkg::HalfSize;
      last = (idx + 1) >= 4 * w;
      r.pixel = band_mem[rd_half * tts_pkg::HalfSize + idx];
      r.last = last && half_final[rd_half];
      tiled_q.push_back(r);
      if (last) begin
        half_full[rd_half] = 1'b0;
        half_final[rd_half] = 1'b0;
        rd_idx = 0;
        rd_half = !rd_half;
      end else begin
        rd_idx = idx + 1;
      end
    end
    if (t.op == tts_pkg::OpPixel && !half_full[wr_half]) begin
      col = wr_col % tts_pkg::MaxWidth;
      row = wr_row % tts_pkg::MaxHeight;
      off = (col >> 3) * 32 + (row & 3) * 8 + (col & 7);
      row_end = (col + 1) >= w;
      final_row = (row + 1) >= h;
      band_mem[wr_half * tts_pkg::HalfSize + off % tts_pkg::HalfSize] = t.pixel;
      if (!row_end) begin
        wr_col = col + 1;
      end else begin
        wr_col = 0;
        if ((row & 3) == 3 || final_row) begin
          half_full[wr_half] = 1'b1;
          half_final[wr_half] = final_row;
          wr_half = !wr_half;
        end
        wr_row = final_row ? 0 : row + 1;
      end
    end
  endfunction

  task automatic queue_item(tts_pkg::op_e op, logic [tts_pkg::PixW-1:0] px);
    pending_q.push_back('{op: op, pixel: px});
    items_queued++;
  endtask

  task automatic wait_drained();
    while (items_sent != items_queued || tiled_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(tts_pkg::cfg_reg_e idx, int unsigned value);
    @(negedge clk_i);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= value[tts_pkg::CfgDataW-1:0];
    do @(posedge clk_i); while (!reg_if.ready);
    if (idx == tts_pkg::RegImageWidth) begin
      cfg_width = value[tts_pkg::WidthW-1:0];
    end else begin
      cfg_height = value[tts_pkg::HeightW-1:0];
    end
    @(negedge clk_i);
    reg_if.valid <= 1'b0;
  endtask

  task automatic start_phase(int unsigned width_raw, int unsigned height_raw);
    wait_drained();
    // let drain ticks still in the pipe retire
    repeat (8) @(posedge clk_i);
    write_reg(tts_pkg::RegImageWidth, width_raw);
    write_reg(tts_pkg::RegImageHeight, height_raw);
  endtask

  task automatic queue_image(int unsigned noise_pct, bit pause_mid);
    int unsigned w, h;
    w = eff_width();
    h = eff_height();
    repeat ($urandom_range(0, 4)) queue_item(tts_pkg::OpDrain, tts_pkg::PixW'($urandom));
    for (int unsigned n = 0; n < w * h; n++) begin
      if (pause_mid && n == w * h / 2) wait_drained();
      if ($urandom_range(0, 99) < noise_pct) begin
        queue_item(tts_pkg::OpDrain, tts_pkg::PixW'($urandom));
      end
      queue_item(tts_pkg::OpPixel, (n < 8) ? CornerPx[n] : tts_pkg::PixW'($urandom));
    end
    // flush the last band
    repeat (4 * w) queue_item(tts_pkg::OpDrain, tts_pkg::PixW'($urandom));
  endtask

  // driver
  always @(negedge clk_i) begin
    pix_txn_t nxt;
    if (!pix_if.valid || pix_taken) begin
      pix_taken = 1'b0;
      if (rst_ni && pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
        nxt = pending_q.pop_front();
        pix_if.valid    <= 1'b1;
        pix_if.opcode   <= nxt.op;
        pix_if.pixel_in <= nxt.pixel;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
    tile_if.ready <= calm || $urandom_range(0, 99) >= IdlePct;
  end

  // monitor
  always @(posedge clk_i) begin
    tile_txn_t want;
    bit        moved;
    moved = 1'b0;
    if (pix_if.valid && pix_if.ready) begin
      swizzle_step('{op: tts_pkg::op_e'(pix_if.opcode), pixel: pix_if.pixel_in});
      pix_taken = 1'b1;
      items_sent++;
      moved = 1'b1;
    end
    if (tile_if.valid && tile_if.ready) begin
      moved = 1'b1;
      if (tiled_q.size() == 0) begin
        $error("unexpected transaction: pixel_out %0h image_end %0b",
               tile_if.pixel_out, tile_if.image_end);
        fail_count++;
      end else begin
        want = tiled_q.pop_front();
        if (tile_if.pixel_out !== want.pixel) begin
          $error("pixel_out mismatch: expected %0h, actual %0h", want.pixel, tile_if.pixel_out);
          fail_count++;
        end
        if (tile_if.image_end !== want.last) begin
          $error("image_end mismatch: expected %0b, actual %0b", want.last, tile_if.image_end);
          fail_count++;
        end
      end
    end
    if (reg_if.valid && reg_if.ready) moved = 1'b1;
    stuck = moved ? 0 : stuck + 1;
    if (stuck >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    pix_if.valid    = 1'b0;
    pix_if.opcode   = tts_pkg::OpPixel;
    pix_if.pixel_in = '0;
    tile_if.ready   = 1'b0;
    reg_if.valid    = 1'b0;
    reg_if.index    = tts_pkg::RegImageWidth;
    reg_if.data     = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // no idling on either side
    calm = 1'b1;
    queue_item(tts_pkg::OpDrain, 8'h00);
    queue_item(tts_pkg::OpDrain, 8'hFF);
    start_phase(8, 4);
    queue_image(0, 1'b0);
    start_phase(0, 0);
    queue_image(0, 1'b0);
    start_phase(15, 21);
    queue_image(10, 1'b1);
    wait_drained();
    calm = 1'b0;

    start_phase(7, 3);
    queue_image(10, 1'b0);

    while (items_queued < RandomStop) begin
      start_phase($urandom_range(0, 40), $urandom_range(0, 11));
      repeat ($urandom_range(1, 2)) queue_image($urandom_range(0, 20), 1'b0);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
